/* hw/rtl/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// shared types and constants of the wildcard pattern search
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int PAT_SLOTS   = 16;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int LEN_W       = 5;
  localparam int MATCH_W     = 32;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_LENGTH       = 3'd2,
    REG_WILD_CHAR    = 3'd3,
    REG_WILD_ENABLE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_SLOTS-1:0][7:0] pattern;
    logic [LEN_W-1:0]          len;
    logic [7:0]                wild_char;
    logic                      wild_en;
  } cfg_t;

endpackage

/* hw/rtl/wps_cfg.sv */
// ----------------------------------------------------------------------------
// wps_cfg
// apb register file; presents the clamped pattern length to the datapath
// ----------------------------------------------------------------------------
module wps_cfg #(
  parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wps_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [wps_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [wps_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output wps_pkg::cfg_t               cfg_o
);
  import wps_pkg::*;

  logic [63:0]      pat_lo_r;
  logic [63:0]      pat_hi_r;
  logic [LEN_W-1:0] len_r;
  logic [7:0]       wchar_r;
  logic             wen_r;
  logic             wr;
  reg_idx_t         idx;
  logic [LEN_W-1:0] len_eff;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= LEN_W'(1);
      wchar_r  <= '0;
      wen_r    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_PATTERN_LOW:  pat_lo_r <= cfg_pwdata;
        REG_PATTERN_HIGH: pat_hi_r <= cfg_pwdata;
        REG_LENGTH:       len_r    <= cfg_pwdata[LEN_W-1:0];
        REG_WILD_CHAR:    wchar_r  <= cfg_pwdata[7:0];
        REG_WILD_ENABLE:  wen_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LOW:  cfg_prdata = pat_lo_r;
      REG_PATTERN_HIGH: cfg_prdata = pat_hi_r;
      REG_LENGTH:       cfg_prdata = CFG_DW'(len_r);
      REG_WILD_CHAR:    cfg_prdata = CFG_DW'(wchar_r);
      REG_WILD_ENABLE:  cfg_prdata = CFG_DW'(wen_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // zero acts as one, anything past the window depth as the depth
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  assign cfg_o.pattern   = {pat_hi_r, pat_lo_r};
  assign cfg_o.len       = len_eff;
  assign cfg_o.wild_char = wchar_r;
  assign cfg_o.wild_en   = wen_r;

endmodule

/* hw/rtl/wps_cell.sv */
// ----------------------------------------------------------------------------
// wps_cell
// one window byte: shifts on from its neighbor and checks the byte it takes
// ----------------------------------------------------------------------------
module wps_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic [7:0] wild_char,
  input  logic       wild_en,
  input  logic       active,
  output logic [7:0] byte_out,
  output logic       match
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign match    = !active || (wild_en && (pat_byte == wild_char)) ||
                    (pat_byte == byte_in);

endmodule

/* hw/rtl/wildcard_pattern_search.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_search
// streaming single-character wildcard search over a shifting byte window
// ----------------------------------------------------------------------------
//  channel  ports       direction  payload
//  in       in_t*       slave      tdata[7:0] text_byte, tuser[0] start_of_text
//  out      out_t*      master     tdata[31:0] match_start, tuser[0] saturated
//  cfg      cfg_p*      apb        five registers at 8-byte spacing
//
// one byte accepted per cycle unless out stalls; a match appears on out in the cycle
// after its byte is accepted; the compare is a row of MAX_PATTERN cells fed as a
// shift chain, then one out register; a stalled out register holds in_tready low
// until it drains; reset needs no clearing pass
// ----------------------------------------------------------------------------
module wildcard_pattern_search #(
  parameter int MAX_PATTERN   = wps_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = wps_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // text_byte
  input  logic [0:0]                   in_tuser,   // start_of_text
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [wps_pkg::MATCH_W-1:0]  out_tdata,  // match_start
  output logic [0:0]                   out_tuser,  // position_saturated
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wps_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [wps_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [wps_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import wps_pkg::*;

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int SW = (POSITION_BITS > MATCH_W) ? POSITION_BITS : MATCH_W;

  cfg_t                     cfg;
  logic                     accept;
  logic                     sot;
  logic [MAX_PATTERN-1:0]   cell_match;
  logic [7:0]               chain [MAX_PATTERN+1];

  logic [FW-1:0]            fill_r, fill_nxt, fill_base;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_base;
  logic                     sat_r, sat_nxt;
  logic                     hit;
  logic [SW-1:0]            start_full;

  logic                     out_valid_r;
  logic [MATCH_W-1:0]       out_data_r;
  logic                     out_sat_r;

  wps_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg_o      (cfg)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign sot       = in_tuser[0];
  assign chain[0]  = in_tdata;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [3:0] pidx;
    logic       active;
    assign pidx   = 4'(cfg.len - LEN_W'(1) - LEN_W'(j));
    assign active = LEN_W'(j) < cfg.len;

    wps_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (chain[j]),
      .pat_byte (cfg.pattern[pidx]),
      .wild_char(cfg.wild_char),
      .wild_en  (cfg.wild_en),
      .active   (active),
      .byte_out (chain[j+1]),
      .match    (cell_match[j])
    );
  end

  // stream counters, cleared by a start-of-text request
  always_comb begin
    fill_base = sot ? '0 : fill_r;
    pos_base  = sot ? '0 : pos_r;
    fill_nxt  = (fill_base == FW'(MAX_PATTERN)) ? fill_base : fill_base + FW'(1);
    if (pos_base == {POSITION_BITS{1'b1}}) begin
      pos_nxt = pos_base;
      sat_nxt = 1'b1;
    end else begin
      pos_nxt = pos_base + POSITION_BITS'(1);
      sat_nxt = sot ? 1'b0 : sat_r;
    end
    hit        = (LEN_W'(fill_nxt) >= cfg.len) && (&cell_match);
    start_full = SW'(pos_base) - SW'(cfg.len - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
      sat_r  <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      sat_r  <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= hit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= start_full[MATCH_W-1:0];
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wildcard pattern search
// ----------------------------------------------------------------------------
// Text bytes are queued by the stimulus process and sent over the in stream by
// a clocked driver. Each accepted byte runs through a local scanner that keeps
// its own window, fill count, position and saturation flag, and any match it
// finds is queued as an expected start position. A clocked monitor pops that
// queue on every accepted out request and compares start and saturation.
// The block is built with a 16-bit position counter. Registers are rewritten
// only while the block is idle, with fixed extreme settings first, random ones
// later, and a fixed all-match setting between the random rounds.
// ----------------------------------------------------------------------------
module tb_top;
  import wps_pkg::*;

  localparam int POS_BITS    = 16;
  localparam int HOLD_CYCLES = 250;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef struct {
    logic [7:0] text_byte;
    logic       start_of_text;
    bit         wait_drain;
  } text_item_t;

  typedef struct {
    logic [31:0] start;
    logic        saturated;
  } match_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_tvalid     = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata      = 8'h00;
  logic [0:0]          in_tuser      = 1'b0;
  logic                out_tvalid;
  logic                out_tready    = 1'b0;
  logic [MATCH_W-1:0]  out_tdata;
  logic [0:0]          out_tuser;
  logic                cfg_psel      = 1'b0;
  logic                cfg_penable   = 1'b0;
  logic                cfg_pwrite    = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr     = '0;
  logic [CFG_DW-1:0]   cfg_pwdata    = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // register copies
  logic [63:0] pat_lo    = '0;
  logic [63:0] pat_hi    = '0;
  logic [4:0]  pat_len   = 5'd1;
  logic [7:0]  wild_char = 8'h00;
  logic        wild_en   = 1'b0;

  // scanner state
  logic [7:0]          win [16];
  int                  win_fill  = 0;
  logic [POS_BITS-1:0] next_pos  = '0;
  logic                pos_sat   = 1'b0;

  text_item_t text_bytes_q [$];
  match_t     expected_matches [$];
  text_item_t offered_byte;
  bit         sending = 1'b0;

  logic [7:0] sym [4];
  int         n_sym = 1;

  int   send_idle  = 0;
  int   recv_idle  = 0;
  logic hold_go    = 1'b0;
  int   hold_left  = 0;
  int   errors     = 0;

  wildcard_pattern_search #(
    .MAX_PATTERN   (16),
    .POSITION_BITS (POS_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic int eff_len();
    if (pat_len == 5'd0) return 1;
    if (pat_len > 5'd16) return 16;
    return int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_byte(int k);
    logic [127:0] all;
    all = {pat_hi, pat_lo};
    return all[8*k +: 8];
  endfunction

  function automatic void scan_text_byte(text_item_t it);
    logic [POS_BITS-1:0] p;
    logic [63:0]         origin;
    logic [7:0]          pb;
    int                  len;
    bit                  hit;
    bit                  wild;
    match_t              m;
    if (it.start_of_text) begin
      foreach (win[i]) win[i] = 8'h00;
      win_fill = 0;
      next_pos = '0;
      pos_sat  = 1'b0;
    end
    p = next_pos;
    for (int i = 15; i > 0; i--) win[i] = win[i-1];
    win[0] = it.text_byte;
    if (win_fill < 16) win_fill++;
    if (p == POS_MAX) pos_sat = 1'b1;
    else next_pos = p + 1'b1;
    len = eff_len();
    hit = (win_fill >= len);
    for (int i = 0; i < len && hit; i++) begin
      pb   = pat_byte(i);
      wild = wild_en && (pb == wild_char);
      if (!wild && pb != win[len-1-i]) hit = 1'b0;
    end
    if (hit) begin
      origin      = 64'(p) - 64'(len - 1);
      m.start     = origin[31:0];
      m.saturated = pos_sat;
      expected_matches.insert(expected_matches.size(), m);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      sending = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_text_byte(offered_byte);
        sending = 1'b0;
      end
      if (!sending) begin
        if (text_bytes_q.size() != 0 &&
            !(text_bytes_q[0].wait_drain && expected_matches.size() != 0) &&
            $urandom_range(99) >= send_idle) begin
          offered_byte = text_bytes_q.pop_front();
          in_tdata  <= offered_byte.text_byte;
          in_tuser  <= offered_byte.start_of_text;
          in_tvalid <= 1'b1;
          sending = 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    out_tready <= !hold_go && hold_left == 0 && $urandom_range(99) >= recv_idle;
  end

  // monitor
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match, expected none, actual start %0d sat %0b",
                 $time, out_tdata, out_tuser[0]);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (out_tdata !== want.start) begin
          $display("%0t: match_start expected %0d actual %0d", $time, want.start, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== want.saturated) begin
          $display("%0t: position_saturated expected %0b actual %0b",
                   $time, want.saturated, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [63:0] v);
    logic [CFG_AW-1:0] a;
    a = CFG_AW'(8 * int'(idx));
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pat_lo    = v;
      REG_PATTERN_HIGH: pat_hi    = v;
      REG_LENGTH:       pat_len   = v[4:0];
      REG_WILD_CHAR:    wild_char = v[7:0];
      REG_WILD_ENABLE:  wild_en   = v[0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [127:0] pat, logic [4:0] len, logic [7:0] wc, logic we);
    apb_write(REG_PATTERN_LOW, pat[63:0]);
    apb_write(REG_PATTERN_HIGH, pat[127:64]);
    apb_write(REG_LENGTH, 64'(len));
    apb_write(REG_WILD_CHAR, 64'(wc));
    apb_write(REG_WILD_ENABLE, 64'(we));
  endtask

  task automatic wait_idle();
    while (text_bytes_q.size() != 0 || sending || expected_matches.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_text(logic [7:0] b, logic sot, bit drain);
    text_item_t it;
    it.text_byte     = b;
    it.start_of_text = sot;
    it.wait_drain    = drain;
    text_bytes_q.insert(text_bytes_q.size(), it);
  endfunction

  // small alphabet, pattern from it with some wildcards; force_len < 0 picks one
  task automatic rand_setup(int force_len);
    logic [127:0] pat;
    logic [7:0]   wc;
    logic         we;
    int           r;
    int           len;
    n_sym = $urandom_range(1, 4);
    foreach (sym[i]) sym[i] = 8'($urandom_range(255));
    r  = $urandom_range(9);
    wc = (r < 3) ? 8'h00 : (r < 6) ? 8'hFF : 8'($urandom_range(255));
    we = 1'($urandom_range(1));
    for (int k = 0; k < 16; k++) begin
      if (we && $urandom_range(3) == 0) pat[8*k +: 8] = wc;
      else if ($urandom_range(9) == 0) pat[8*k +: 8] = 8'($urandom_range(255));
      else pat[8*k +: 8] = sym[$urandom_range(n_sym - 1)];
    end
    if (force_len >= 0) len = force_len;
    else if ($urandom_range(3) == 0) len = $urandom_range(31);
    else len = $urandom_range(1, 8);
    write_all(pat, 5'(len), wc, we);
  endtask

  // text with embedded pattern copies, some cut short, plus noise
  task automatic add_text(int count, int sot_pct, bit sot_first);
    logic [7:0] pb;
    logic [7:0] b;
    int         n;
    int         len;
    int         r;
    int         cut;
    n   = 0;
    len = eff_len();
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 30) begin
        cut = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : len;
        for (int k = 0; k < cut && n < count; k++) begin
          pb = pat_byte(k);
          b  = (wild_en && pb == wild_char) ? 8'($urandom_range(255)) : pb;
          push_text(b, (n == 0 && sot_first) || $urandom_range(99) < sot_pct,
                    n == 0 || $urandom_range(199) == 0);
          n++;
        end
      end else begin
        b = (r < 42) ? 8'($urandom_range(255)) : sym[$urandom_range(n_sym - 1)];
        push_text(b, (n == 0 && sot_first) || $urandom_range(99) < sot_pct,
                  n == 0 || $urandom_range(199) == 0);
        n++;
      end
    end
  endtask

  initial begin
    int lens_a [5];
    int lens_b [5];
    lens_a = '{1, 16, 0, 31, -1};
    lens_b = '{-1, 2, 17, -1, 16};
    foreach (win[i]) win[i] = 8'h00;
    foreach (sym[i]) sym[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 27;
    recv_idle = 49;

    // reset settings: single zero byte, exact
    push_text(8'h00, 1'b0, 1'b0);
    push_text(8'hFF, 1'b0, 1'b0);
    push_text(8'h00, 1'b1, 1'b0);
    wait_idle();

    // zero length acts as one, all-ones wildcard matches anything
    write_all('1, 5'd0, 8'hFF, 1'b1);
    push_text(8'h5A, 1'b0, 1'b0);
    push_text(8'hA5, 1'b0, 1'b0);
    wait_idle();

    // oversize length acts as 16, window must fill first, wildcard off
    write_all({64'h0F0E0D0C0B0A0908, 64'h0706050403020100}, 5'd31, 8'h00, 1'b0);
    for (int k = 0; k < 17; k++) push_text(8'(k), k == 0, 1'b0);
    wait_idle();

    for (int j = 0; j < 5; j++) begin
      rand_setup(lens_a[j]);
      add_text(103, 2, 1'b1);
      wait_idle();
    end

    send_idle = 49;
    recv_idle = 27;

    // every byte matches; receiver stalls long so the input backs up
    write_all(128'hA5, 5'd1, 8'hA5, 1'b1);
    for (int k = 0; k < 60; k++) push_text(8'($urandom_range(255)), k == 0, 1'b0);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_idle();

    for (int j = 0; j < 5; j++) begin
      rand_setup(lens_b[j]);
      add_text(103, 2, 1'b1);
      wait_idle();
    end

    send_idle = 0;
    recv_idle = 0;

    rand_setup(3);
    add_text(40, 0, 1'b1);
    wait_idle();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #18_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/wps_pkg.sv
hw/rtl/wps_cfg.sv
hw/rtl/wps_cell.sv
hw/rtl/wildcard_pattern_search.sv
tb/sv/tb_top.sv
